/* rtl/fsia_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsia_pkg
// Shared types and constants for the floor-semantics integer ALU.
// ----------------------------------------------------------------------------
package fsia_pkg;

    localparam int DataWidth = 64;
    localparam int CntWidth  = $clog2(DataWidth + 1);
    localparam int QueueDepth = 2;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MOD  = 4'd4,
        OP_POW  = 4'd5,
        OP_NEG  = 4'd6,
        OP_LT   = 4'd7,
        OP_LE   = 4'd8,
        OP_GT   = 4'd9,
        OP_GE   = 4'd10,
        OP_EQ   = 4'd11,
        OP_NE   = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERODIV = 2'd1,
        ST_NEGEXP  = 2'd2
    } status_t;

    // Work class decided by the front end
    typedef enum logic [1:0] {
        CLS_DONE = 2'd0,
        CLS_MUL  = 2'd1,
        CLS_DIV  = 2'd2,
        CLS_POW  = 2'd3
    } cls_t;

    // One classified request as it travels through the queue
    typedef struct packed {
        cls_t                  cls;
        logic                  want_mod;
        logic [DataWidth-1:0]  a;
        logic [DataWidth-1:0]  b;
        logic [DataWidth-1:0]  value;
        status_t               status;
    } req_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_DIVFIX,
        BK_POW_MUL,
        BK_POW_SQ,
        BK_DONE
    } bk_state_t;

endpackage : fsia_pkg
`default_nettype wire

/* rtl/fsia_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsia_front
// Classifies a request: finishes add, sub, neg, compares and error cases, and flags the rest.
// ----------------------------------------------------------------------------
module fsia_front
    import fsia_pkg::*;
(
    input  wire logic [3:0]           kind,
    input  wire logic [DataWidth-1:0] operand_a,
    input  wire logic [DataWidth-1:0] operand_b,
    output req_t                      req
);

    logic signed [DataWidth-1:0] sa;
    logic signed [DataWidth-1:0] sb;
    logic                        lt_ab;
    logic                        lt_ba;

    assign sa    = operand_a;
    assign sb    = operand_b;
    assign lt_ab = sa < sb;
    assign lt_ba = sb < sa;

    // Decode the operation
    always_comb
    begin
        req.cls      = CLS_DONE;
        req.want_mod = 1'b0;
        req.a        = operand_a;
        req.b        = operand_b;
        req.value    = '0;
        req.status   = ST_OK;
        unique case (kind)
            OP_ADD: req.value = operand_a + operand_b;
            OP_SUB: req.value = operand_a - operand_b;
            OP_MUL: req.cls = CLS_MUL;
            OP_DIV, OP_MOD:
            begin
                req.want_mod = (kind == OP_MOD);
                if (operand_b == '0)
                    req.status = ST_ZERODIV;
                else
                    req.cls = CLS_DIV;
            end
            OP_POW:
            begin
                if (operand_b[DataWidth-1])
                    req.status = ST_NEGEXP;
                else
                    req.cls = CLS_POW;
            end
            OP_NEG: req.value = '0 - operand_a;
            OP_LT:  req.value = DataWidth'(lt_ab);
            OP_LE:  req.value = DataWidth'(!lt_ba);
            OP_GT:  req.value = DataWidth'(lt_ba);
            OP_GE:  req.value = DataWidth'(!lt_ab);
            OP_EQ:  req.value = DataWidth'(operand_a == operand_b);
            OP_NE:  req.value = DataWidth'(operand_a != operand_b);
            default: req.value = '0;
        endcase
    end

endmodule : fsia_front
`default_nettype wire

/* rtl/fsia_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsia_queue
// Two-entry request queue between front end and execution unit.
// ----------------------------------------------------------------------------
module fsia_queue
    import fsia_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  req_t      push_data,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output req_t      pop_data
);

    localparam int PtrWidth = $clog2(QueueDepth);

    req_t                 mem [QueueDepth];
    logic [PtrWidth-1:0]  wr_ptr_reg;
    logic [PtrWidth-1:0]  rd_ptr_reg;
    logic [PtrWidth:0]    count_reg;

    assign full     = (count_reg == (PtrWidth+1)'(QueueDepth));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule : fsia_queue
`default_nettype wire

/* rtl/fsia_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsia_back
// Execution unit: 32x32 partial-product multiplier, bit-serial divider,
// square-and-multiply power loop sharing the multiplier.
// ----------------------------------------------------------------------------
module fsia_back
    import fsia_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 empty,
    input  req_t                      req,
    output logic                      pop,
    output logic                      done,
    output logic [DataWidth-1:0]      value,
    output logic [1:0]                status
);

    localparam int HalfWidth = (DataWidth + 1) / 2;
    localparam int ProdWidth = 2 * HalfWidth;

    bk_state_t               state_reg;
    bk_state_t               state_next;

    // Multiplier sequencer: three partial products, one per cycle
    logic [1:0]              mstep_reg;
    logic [DataWidth-1:0]    mx_reg;
    logic [DataWidth-1:0]    my_reg;
    logic [DataWidth-1:0]    macc_reg;
    logic [HalfWidth-1:0]    pp_x;
    logic [HalfWidth-1:0]    pp_y;
    logic [ProdWidth-1:0]    pp;
    logic [ProdWidth+DataWidth-1:0] pp_ext;
    logic [ProdWidth+DataWidth-1:0] pp_shift;

    // Divider
    logic [DataWidth-1:0]    dq_reg;
    logic [DataWidth-1:0]    drem_reg;
    logic [DataWidth-1:0]    dden_reg;
    logic                    aneg_reg;
    logic                    bneg_reg;
    logic                    want_mod_reg;
    logic [DataWidth-1:0]    b_orig_reg;
    logic [CntWidth-1:0]     cnt_reg;
    logic [DataWidth:0]      trial;
    logic [DataWidth:0]      shifted;

    // Power
    logic [DataWidth-1:0]    base_reg;
    logic [DataWidth-1:0]    exp_reg;
    logic [DataWidth-1:0]    pacc_reg;

    logic [DataWidth-1:0]    res_reg;
    logic [1:0]              st_reg;
    logic                    mul_last;
    logic [DataWidth-1:0]    mul_out;
    logic [DataWidth-1:0]    q_fix;
    logic [DataWidth-1:0]    r_fix;

    // Pick one 32x32 partial product per step
    always_comb
    begin
        unique case (mstep_reg)
            2'd0:    begin pp_x = mx_reg[HalfWidth-1:0]; pp_y = my_reg[HalfWidth-1:0]; end
            2'd1:    begin pp_x = HalfWidth'(mx_reg >> HalfWidth);
                           pp_y = my_reg[HalfWidth-1:0]; end
            default: begin pp_x = mx_reg[HalfWidth-1:0];
                           pp_y = HalfWidth'(my_reg >> HalfWidth); end
        endcase
    end

    assign pp       = pp_x * pp_y;
    assign pp_ext   = (ProdWidth+DataWidth)'(pp);
    assign pp_shift = (mstep_reg == 2'd0) ? pp_ext : (pp_ext << HalfWidth);
    assign mul_out  = macc_reg + pp_shift[DataWidth-1:0];
    assign mul_last = (mstep_reg == 2'd2);

    assign shifted  = {drem_reg, dq_reg[DataWidth-1]};
    assign trial    = shifted - {1'b0, dden_reg};

    // Floor correction of the truncated quotient and remainder
    always_comb
    begin
        logic [DataWidth-1:0] tq;
        logic [DataWidth-1:0] tr;
        tq = (aneg_reg != bneg_reg) ? ('0 - dq_reg) : dq_reg;
        tr = aneg_reg ? ('0 - drem_reg) : drem_reg;
        if (drem_reg != '0 && aneg_reg != bneg_reg)
        begin
            tq = tq - 1'b1;
            tr = tr + b_orig_reg;
        end
        q_fix = tq;
        r_fix = tr;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    unique case (req.cls)
                        CLS_MUL:  state_next = BK_MUL;
                        CLS_DIV:  state_next = BK_DIV;
                        CLS_POW:  state_next = BK_POW_MUL;
                        default:  state_next = BK_DONE;
                    endcase
                end
            end
            BK_MUL:     if (mul_last) state_next = BK_DONE;
            BK_DIV:     if (cnt_reg == CntWidth'(1)) state_next = BK_DIVFIX;
            BK_DIVFIX:  state_next = BK_DONE;
            BK_POW_MUL:
            begin
                if (exp_reg == '0)
                    state_next = BK_DONE;
                else if (!exp_reg[0] || mul_last)
                    state_next = BK_POW_SQ;
            end
            BK_POW_SQ:  if (mul_last) state_next = BK_POW_MUL;
            BK_DONE:    state_next = BK_IDLE;
            default:    state_next = BK_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        pop    = (state_reg == BK_IDLE) && !empty;
        done   = (state_reg == BK_DONE);
        value  = res_reg;
        status = st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                // Power starts with accumulator times base, i.e. 1 * a
                mstep_reg    <= 2'd0;
                macc_reg     <= '0;
                mx_reg       <= (req.cls == CLS_POW) ? DataWidth'(1) : req.a;
                my_reg       <= (req.cls == CLS_POW) ? req.a : req.b;
                res_reg      <= req.value;
                st_reg       <= req.status;
                want_mod_reg <= req.want_mod;
                aneg_reg     <= req.a[DataWidth-1];
                bneg_reg     <= req.b[DataWidth-1];
                b_orig_reg   <= req.b;
                dq_reg       <= req.a[DataWidth-1] ? ('0 - req.a) : req.a;
                dden_reg     <= req.b[DataWidth-1] ? ('0 - req.b) : req.b;
                drem_reg     <= '0;
                cnt_reg      <= CntWidth'(DataWidth);
                base_reg     <= req.a;
                exp_reg      <= req.b;
                pacc_reg     <= DataWidth'(1);
            end
            BK_MUL:
            begin
                macc_reg  <= mul_out;
                mstep_reg <= mstep_reg + 2'd1;
                if (mul_last)
                    res_reg <= mul_out;
            end
            BK_DIV:
            begin
                if (!trial[DataWidth])
                begin
                    drem_reg <= trial[DataWidth-1:0];
                    dq_reg   <= {dq_reg[DataWidth-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= shifted[DataWidth-1:0];
                    dq_reg   <= {dq_reg[DataWidth-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
            BK_DIVFIX:
                res_reg <= want_mod_reg ? r_fix : q_fix;
            BK_POW_MUL:
            begin
                if (exp_reg == '0)
                    res_reg <= pacc_reg;
                else if (!exp_reg[0])
                begin
                    // Skip the multiply, set up the square
                    mx_reg    <= base_reg;
                    my_reg    <= base_reg;
                    macc_reg  <= '0;
                    mstep_reg <= 2'd0;
                end
                else if (mul_last)
                begin
                    pacc_reg  <= mul_out;
                    mx_reg    <= base_reg;
                    my_reg    <= base_reg;
                    macc_reg  <= '0;
                    mstep_reg <= 2'd0;
                end
                else
                begin
                    macc_reg  <= mul_out;
                    mstep_reg <= mstep_reg + 2'd1;
                end
            end
            BK_POW_SQ:
            begin
                if (mul_last)
                begin
                    base_reg  <= mul_out;
                    exp_reg   <= exp_reg >> 1;
                    macc_reg  <= '0;
                    mstep_reg <= 2'd0;
                    mx_reg    <= pacc_reg;
                    my_reg    <= mul_out;
                end
                else
                begin
                    macc_reg  <= mul_out;
                    mstep_reg <= mstep_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

endmodule : fsia_back
`default_nettype wire

/* rtl/floor_semantics_integer_alu.sv */
`default_nettype none
// Execution: add/sub/neg/compare are computed in the front end; floordiv/mod take one
//   quotient bit per cycle in the serial divider; pow does a multiply and a square per set
//   exponent bit and only a square per clear bit, three 32x32 partial products per multiply.
// Throughput: one request in flight in the execution unit; the two-entry
//   queue lets start be taken while it works. Results cannot be stalled.
// Reset: rst_n clears the queue and the execution state machine.
// ----------------------------------------------------------------------------
// floor_semantics_integer_alu
// Integer ALU with floor division, floor modulo and power by squaring.
// ----------------------------------------------------------------------------
module floor_semantics_integer_alu
    import fsia_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [3:0]                  kind,
    input  wire logic signed [DataWidth-1:0] operand_a,
    input  wire logic signed [DataWidth-1:0] operand_b,
    output logic                             done,
    output logic signed [DataWidth-1:0]      value,
    output logic [1:0]                       status
);

    req_t                 front_req;
    req_t                 q_req;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    logic                 push;
    logic [DataWidth-1:0] back_value;

    assign busy  = q_full;
    assign push  = start && !q_full;
    assign value = back_value;

    fsia_front u_front (
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .req       (front_req)
    );

    fsia_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_req),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_req)
    );

    fsia_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (q_empty),
        .req    (q_req),
        .pop    (q_pop),
        .done   (done),
        .value  (back_value),
        .status (status)
    );

    // Never pop an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty) else $error("pop from empty queue");

    // A result is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held high");

    // Status codes stay in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status != 2'd3)) else $error("bad status");

endmodule : floor_semantics_integer_alu
`default_nettype wire

/* tb/floor_semantics_integer_alu_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// floor_semantics_integer_alu_tb
// Drives directed and random requests into the floor-semantics ALU, predicts
// each value and status in the bench, and checks results in order.
// ----------------------------------------------------------------------------
module floor_semantics_integer_alu_tb;
    import fsia_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [3:0]  kind;
        logic [63:0] a;
        logic [63:0] b;
    } alu_req_t;

    typedef struct {
        logic [63:0] value;
        logic [1:0]  status;
    } alu_res_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         kind;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic               done;
    logic signed [63:0] value;
    logic [1:0]         status;

    alu_req_t pending_reqs[$];
    alu_res_t expected_results[$];
    int       error_count = 0;
    int       checked_count = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    bit       stim_done = 0;

    floor_semantics_integer_alu dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .operand_a(operand_a), .operand_b(operand_b), .done(done),
        .value(value), .status(status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Compute floor quotient and floor remainder, signed 64-bit
    function automatic void floor_divide(input logic [63:0] a, input logic [63:0] b,
                                         output logic [63:0] q, output logic [63:0] r);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] uq;
        logic [63:0] ur;
        logic        differ;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        uq = ua / ub;
        ur = ua % ub;
        differ = a[63] != b[63];
        q = differ ? -uq : uq;
        r = a[63] ? -ur : ur;
        if (ur != 0 && differ)
        begin
            q = q - 1;
            r = r + b;
        end
    endfunction

    function automatic alu_res_t alu_predict(input alu_req_t req);
        alu_res_t    res;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] base;
        logic [63:0] e;
        res.value = '0;
        res.status = ST_OK;
        case (req.kind)
            OP_ADD: res.value = req.a + req.b;
            OP_SUB: res.value = req.a - req.b;
            OP_MUL: res.value = req.a * req.b;
            OP_DIV, OP_MOD:
            begin
                if (req.b == 0)
                    res.status = ST_ZERODIV;
                else
                begin
                    floor_divide(req.a, req.b, q, r);
                    res.value = (req.kind == OP_DIV) ? q : r;
                end
            end
            OP_POW:
            begin
                if (req.b[63])
                    res.status = ST_NEGEXP;
                else
                begin
                    res.value = 64'd1;
                    base = req.a;
                    e = req.b;
                    while (e != 0)
                    begin
                        if (e[0])
                            res.value = res.value * base;
                        base = base * base;
                        e = e >> 1;
                    end
                end
            end
            OP_NEG: res.value = -req.a;
            OP_LT: res.value = ($signed(req.a) < $signed(req.b)) ? 64'd1 : 64'd0;
            OP_LE: res.value = ($signed(req.a) <= $signed(req.b)) ? 64'd1 : 64'd0;
            OP_GT: res.value = ($signed(req.a) > $signed(req.b)) ? 64'd1 : 64'd0;
            OP_GE: res.value = ($signed(req.a) >= $signed(req.b)) ? 64'd1 : 64'd0;
            OP_EQ: res.value = (req.a == req.b) ? 64'd1 : 64'd0;
            OP_NE: res.value = (req.a != req.b) ? 64'd1 : 64'd0;
            default: res.value = '0;
        endcase
        return res;
    endfunction

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = 64'(signed'($urandom_range(0, 20)) - 10);
            1: v = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            2: v = 64'(signed'(int'($urandom)));
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_req(input logic [3:0] k, input logic [63:0] a, input logic [63:0] b);
        alu_req_t req;
        req.kind = k;
        req.a = a;
        req.b = b;
        pending_reqs.push_back(req);
    endtask

    // Fill the request queue: directed corners, then random
    initial
    begin
        logic [63:0] a;
        logic [63:0] b;
        logic [3:0]  k;
        queue_req(OP_ADD, 64'h7fff_ffff_ffff_ffff, 64'd1);
        queue_req(OP_SUB, 64'h8000_0000_0000_0000, 64'd1);
        queue_req(OP_MUL, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        queue_req(OP_DIV, -64'd7, 64'd2);
        queue_req(OP_MOD, -64'd7, 64'd2);
        queue_req(OP_MOD, 64'd7, -64'd2);
        queue_req(OP_DIV, 64'd5, 64'd0);
        queue_req(OP_MOD, 64'd5, 64'd0);
        queue_req(OP_DIV, 64'h8000_0000_0000_0000, -64'd1);
        queue_req(OP_MOD, 64'h8000_0000_0000_0000, -64'd1);
        queue_req(OP_POW, 64'd0, 64'd0);
        queue_req(OP_POW, 64'd3, 64'd40);
        queue_req(OP_POW, 64'd2, -64'd1);
        queue_req(OP_POW, -64'd1, 64'h7fff_ffff_ffff_ffff);
        queue_req(OP_NEG, 64'h8000_0000_0000_0000, 64'hdead_beef);
        queue_req(OP_LT, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
        queue_req(OP_LE, 64'd4, 64'd4);
        queue_req(OP_GT, -64'd1, 64'd0);
        queue_req(OP_GE, 64'd4, 64'd4);
        queue_req(OP_EQ, -64'd3, -64'd3);
        queue_req(OP_NE, -64'd3, -64'd3);
        queue_req(4'd13, 64'd1, 64'd2);
        queue_req(4'd15, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        repeat (1300)
        begin
            k = 4'($urandom_range(0, 15));
            if (k > 12 && $urandom_range(0, 3) != 0)
                k = 4'($urandom_range(0, 12));
            a = rand_operand();
            b = rand_operand();
            // Keep most divisions nonzero and most exponents small and nonnegative
            if ((k == OP_DIV || k == OP_MOD) && b == 0 && $urandom_range(0, 1))
                b = 64'd3;
            if (k == OP_POW && $urandom_range(0, 3) != 0)
                b = 64'($urandom_range(0, 70));
            queue_req(k, a, b);
        end
        stim_done = 1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Send requests in bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        alu_req_t req;
        if (!rst_n)
        begin
            start <= 1'b0;
            kind <= '0;
            operand_a <= '0;
            operand_b <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_results.push_back(alu_predict('{kind, operand_a, operand_b}));
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                req = pending_reqs.pop_front();
                start <= 1'b1;
                kind <= req.kind;
                operand_a <= req.a;
                operand_b <= req.b;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Check each strobed result against the oldest prediction
    always @(posedge clk)
    begin
        alu_res_t exp_res;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result value=%h status=%0d", $time, value, status);
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                checked_count++;
                if (value !== exp_res.value)
                begin
                    $display("%0t: value mismatch expected=%h actual=%h",
                             $time, exp_res.value, value);
                    error_count++;
                end
                if (status !== exp_res.status)
                begin
                    $display("%0t: status mismatch expected=%0d actual=%0d",
                             $time, exp_res.status, status);
                    error_count++;
                end
            end
        end
    end

    // Wait for the drain, then report
    initial
    begin
        wait (rst_n && stim_done);
        while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
        $display("Checked %0d results over all thirteen operations plus undefined codes,",
                 checked_count);
        $display("including zero divisors, negative exponents and wrap corners.");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
rtl/fsia_pkg.sv
rtl/fsia_front.sv
rtl/fsia_queue.sv
rtl/fsia_back.sv
rtl/floor_semantics_integer_alu.sv
tb/floor_semantics_integer_alu_tb.sv
